@@ sv/clp_pkg.sv @@
// package for the canonical line block: shared constants
`timescale 1ns / 1ps
`default_nettype none
package clp_pkg;
   localparam int COORD_BITS_DEF = 12;
endpackage
`default_nettype wire

@@ sv/canonical_line_from_two_points_top.sv @@
// top level: normalized integer line through two points
//
//  channel  dir  ports
//  req      in   req_valid, req_stall, req_first_x/y, req_second_x/y
//  rsp      out  rsp_valid, rsp_stall, rsp_coef_dy/dx/const, rsp_degenerate
//
// the pipeline runs through the gcd step chain of 2*COORD_BITS stages
// and the COORD_BITS-stage divider
// a new word can enter every cycle while req_stall is low
// a stalled result freezes the whole pipeline; req_stall follows it
// reset clears the valid bits only
`timescale 1ns / 1ps
`default_nettype none
module canonical_line_from_two_points_top #(
   parameter int COORD_BITS = clp_pkg::COORD_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_first_x,
   input  wire logic signed [COORD_BITS-1:0] req_first_y,
   input  wire logic signed [COORD_BITS-1:0] req_second_x,
   input  wire logic signed [COORD_BITS-1:0] req_second_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [COORD_BITS:0]        rsp_coef_dy,
   output logic [COORD_BITS-1:0]             rsp_coef_dx,
   output logic signed [2*COORD_BITS:0]      rsp_coef_const,
   output logic                              rsp_degenerate
);
   localparam int CB = COORD_BITS;
   localparam int SBD = 3 + 2 * CB;
   localparam int SBG = SBD + 2 * CB;

   logic                en;
   logic                va_ff;
   logic signed [CB:0]  dy_ff;
   logic signed [CB:0]  dx_ff;
   logic [CB-1:0]       x1_ff;
   logic [CB-1:0]       y1_ff;
   logic                dy_neg;
   logic                dx_neg;
   logic                deg;
   logic [CB-1:0]       mag_dy;
   logic [CB-1:0]       mag_dx;
   logic                g_valid;
   logic [CB-1:0]       g_gcd;
   logic [SBG-1:0]      g_side;
   logic                d_valid;
   logic [CB-1:0]       d_q0;
   logic [CB-1:0]       d_q1;
   logic [SBD-1:0]      d_side;
   logic                flip;
   logic                v1_ff;
   logic signed [CB:0]  cdy_ff;
   logic [CB-1:0]       cdx_ff;
   logic signed [CB-1:0] px_ff;
   logic signed [CB-1:0] py_ff;
   logic                deg1_ff;
   logic                v2_ff;
   logic signed [2*CB:0] p1_ff;
   logic signed [2*CB:0] p2_ff;
   logic signed [CB:0]  cdy2_ff;
   logic [CB-1:0]       cdx2_ff;
   logic                deg2_ff;
   logic signed [2*CB:0] csum;
   logic                rsp_valid_ff;
   logic signed [CB:0]  rsp_coef_dy_ff;
   logic [CB-1:0]       rsp_coef_dx_ff;
   logic signed [2*CB:0] rsp_coef_const_ff;
   logic                rsp_degenerate_ff;

   assign en = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // differences
   always_ff @(posedge clock) begin
      if (en) begin
         dy_ff <= {req_first_y[CB-1], req_first_y} - {req_second_y[CB-1], req_second_y};
         dx_ff <= {req_second_x[CB-1], req_second_x} - {req_first_x[CB-1], req_first_x};
         x1_ff <= req_first_x;
         y1_ff <= req_first_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid && !req_stall;
      end
   end

   assign dy_neg = dy_ff[CB];
   assign dx_neg = dx_ff[CB];
   assign deg = (dy_ff == '0) && (dx_ff == '0);
   assign mag_dy = dy_neg ? CB'(-dy_ff) : dy_ff[CB-1:0];
   assign mag_dx = dx_neg ? CB'(-dx_ff) : dx_ff[CB-1:0];

   clp_gcd_pipe #(.CB(CB), .SB(SBG)) u_gcd (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (va_ff),
      .in_a     (mag_dy),
      .in_b     (mag_dx),
      .in_side  ({deg, dy_neg, dx_neg, x1_ff, y1_ff, mag_dy, mag_dx}),
      .out_valid(g_valid),
      .out_gcd  (g_gcd),
      .out_side (g_side)
   );

   clp_div_pipe #(.CB(CB), .SB(SBD)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (g_valid),
      .in_div   (g_gcd),
      .in_n0    (g_side[2*CB-1:CB]),
      .in_n1    (g_side[CB-1:0]),
      .in_side  (g_side[SBG-1:2*CB]),
      .out_valid(d_valid),
      .out_q0   (d_q0),
      .out_q1   (d_q1),
      .out_side (d_side)
   );

   // sign normalization: dx positive, or dx zero and dy positive
   assign flip = d_side[SBD-3] || ((d_q1 == '0) && d_side[SBD-2]);

   always_ff @(posedge clock) begin
      if (en) begin
         cdy_ff <= (d_side[SBD-2] ^ flip) ? -$signed({1'b0, d_q0}) : $signed({1'b0, d_q0});
         cdx_ff <= d_q1;
         px_ff <= $signed(d_side[2*CB-1:CB]);
         py_ff <= $signed(d_side[CB-1:0]);
         deg1_ff <= d_side[SBD-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= (2*CB+1)'(cdy_ff) * (2*CB+1)'(px_ff);
         p2_ff <= (2*CB+1)'($signed({1'b0, cdx_ff})) * (2*CB+1)'(py_ff);
         cdy2_ff <= cdy_ff;
         cdx2_ff <= cdx_ff;
         deg2_ff <= deg1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= d_valid;
         v2_ff <= v1_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   // c = -(dy*x1 + dx*y1) on the reduced coefficients
   assign csum = p1_ff + p2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_degenerate_ff <= deg2_ff;
         rsp_coef_dy_ff <= deg2_ff ? '0 : cdy2_ff;
         rsp_coef_dx_ff <= deg2_ff ? '0 : cdx2_ff;
         rsp_coef_const_ff <= deg2_ff ? '0 : (2*CB+1)'(-csum);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_coef_dy = rsp_coef_dy_ff;
   assign rsp_coef_dx = rsp_coef_dx_ff;
   assign rsp_coef_const = rsp_coef_const_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

`ifndef ASSERT_OFF
   a_canon_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> (rsp_coef_dx != '0) || (rsp_coef_dy > 0))
      else $error("line not in canonical sign form");
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> (rsp_coef_dx == '0) && (rsp_coef_dy == '0)
         && (rsp_coef_const == '0))
      else $error("degenerate result with nonzero coefficients");
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      g_valid && !g_side[SBG-1] |-> g_gcd != '0)
      else $error("zero gcd for distinct points");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_coef_const))
      else $error("pipeline advanced under stall");
`endif
endmodule
`default_nettype wire

@@ sv/clp_gcd_pipe.sv @@
// pipelined binary gcd of two unsigned magnitudes, one step per stage
`timescale 1ns / 1ps
`default_nettype none
module clp_gcd_pipe #(
   parameter int CB = clp_pkg::COORD_BITS_DEF,
   parameter int SB = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [CB-1:0] in_a,
   input  wire logic [CB-1:0] in_b,
   input  wire logic [SB-1:0] in_side,
   output logic               out_valid,
   output logic [CB-1:0]      out_gcd,
   output logic [SB-1:0]      out_side
);
   localparam int NSTEP = 2 * CB;
   localparam int KW = $clog2(CB + 1);

   logic [CB-1:0] a_ff [0:NSTEP];
   logic [CB-1:0] b_ff [0:NSTEP];
   logic [KW-1:0] k_ff [0:NSTEP];
   logic [SB-1:0] side_ff [0:NSTEP];
   logic          v_ff [0:NSTEP];
   logic [KW-1:0] k_in;
   logic          found;
   logic          out_valid_ff;
   logic [CB-1:0] out_gcd_ff;
   logic [SB-1:0] out_side_ff;

   // common factors of two
   always_comb begin
      k_in = '0;
      found = 1'b0;
      for (int i = 0; i < CB; i++) begin
         if (!found) begin
            if (in_a[i] | in_b[i]) begin
               found = 1'b1;
            end else begin
               k_in = KW'(k_in + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= in_a >> k_in;
         b_ff[0] <= in_b >> k_in;
         k_ff[0] <= k_in;
         side_ff[0] <= in_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   for (genvar s = 0; s < NSTEP; s++) begin : g_step
      logic [CB-1:0] a_in;
      logic [CB-1:0] b_in;
      always_comb begin
         a_in = a_ff[s];
         b_in = b_ff[s];
         if (a_ff[s] == '0 || b_ff[s] == '0) begin
            a_in = a_ff[s];
         end else if (!a_ff[s][0]) begin
            a_in = a_ff[s] >> 1;
         end else if (!b_ff[s][0]) begin
            b_in = b_ff[s] >> 1;
         end else if (a_ff[s] >= b_ff[s]) begin
            a_in = CB'(a_ff[s] - b_ff[s]) >> 1;
         end else begin
            b_in = CB'(b_ff[s] - a_ff[s]) >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[s+1] <= a_in;
            b_ff[s+1] <= b_in;
            k_ff[s+1] <= k_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_gcd_ff <= CB'((a_ff[NSTEP] | b_ff[NSTEP]) << k_ff[NSTEP]);
         out_side_ff <= side_ff[NSTEP];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_gcd = out_gcd_ff;
   assign out_side = out_side_ff;
endmodule
`default_nettype wire

@@ sv/clp_div_pipe.sv @@
// pipelined restoring divider, two dividends over one divisor, one bit per stage
`timescale 1ns / 1ps
`default_nettype none
module clp_div_pipe #(
   parameter int CB = clp_pkg::COORD_BITS_DEF,
   parameter int SB = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [CB-1:0] in_div,
   input  wire logic [CB-1:0] in_n0,
   input  wire logic [CB-1:0] in_n1,
   input  wire logic [SB-1:0] in_side,
   output logic               out_valid,
   output logic [CB-1:0]      out_q0,
   output logic [CB-1:0]      out_q1,
   output logic [SB-1:0]      out_side
);
   logic [CB-1:0] rem_ff [0:CB][0:1];
   logic [CB-1:0] num_ff [0:CB][0:1];
   logic [CB-1:0] quo_ff [0:CB][0:1];
   logic [CB-1:0] div_ff [0:CB];
   logic [SB-1:0] side_ff [0:CB];
   logic          v_ff [0:CB];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0][0] <= '0;
         rem_ff[0][1] <= '0;
         num_ff[0][0] <= in_n0;
         num_ff[0][1] <= in_n1;
         quo_ff[0][0] <= '0;
         quo_ff[0][1] <= '0;
         div_ff[0] <= in_div;
         side_ff[0] <= in_side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   for (genvar s = 0; s < CB; s++) begin : g_bit
      logic [CB-1:0] rem_in [0:1];
      logic [CB-1:0] quo_in [0:1];
      logic [CB:0]   trial [0:1];
      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l] = {rem_ff[s][l], num_ff[s][l][CB-1]};
            if (trial[l] >= {1'b0, div_ff[s]}) begin
               rem_in[l] = CB'(trial[l] - {1'b0, div_ff[s]});
               quo_in[l] = {quo_ff[s][l][CB-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[l][CB-1:0];
               quo_in[l] = {quo_ff[s][l][CB-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 2; l++) begin
               rem_ff[s+1][l] <= rem_in[l];
               quo_ff[s+1][l] <= quo_in[l];
               num_ff[s+1][l] <= num_ff[s][l] << 1;
            end
            div_ff[s+1] <= div_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en) begin
            v_ff[s+1] <= v_ff[s];
         end
      end
   end

   assign out_valid = v_ff[CB];
   assign out_q0 = quo_ff[CB][0];
   assign out_q1 = quo_ff[CB][1];
   assign out_side = side_ff[CB];
endmodule
`default_nettype wire

@@ tb/canonical_line_from_two_points_top_tb.sv @@
// testbench for the canonical line block: directed and random point pairs against a predictor
`timescale 1ns / 1ps
`default_nettype none
module canonical_line_from_two_points_top_tb;
   localparam int CB = clp_pkg::COORD_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [CB:0]   dy;
      logic [CB-1:0]        dx;
      logic signed [2*CB:0] cst;
      logic                 degen;
   } line_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_first_x = '0, req_first_y = '0;
   logic signed [CB-1:0] req_second_x = '0, req_second_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [CB:0] rsp_coef_dy;
   logic [CB-1:0] rsp_coef_dx;
   logic signed [2*CB:0] rsp_coef_const;
   logic rsp_degenerate;

   line_type expected_lines[$];
   int errors = 0;
   int lines_checked = 0;
   int degenerate_seen = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;

   always #2 clock = ~clock;

   canonical_line_from_two_points_top #(.COORD_BITS(CB)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_x(req_first_x), .req_first_y(req_first_y),
      .req_second_x(req_second_x), .req_second_y(req_second_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_coef_dy(rsp_coef_dy), .rsp_coef_dx(rsp_coef_dx),
      .rsp_coef_const(rsp_coef_const), .rsp_degenerate(rsp_degenerate)
   );

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic line_type line_through(logic signed [CB-1:0] x1, logic signed [CB-1:0] y1,
                                             logic signed [CB-1:0] x2, logic signed [CB-1:0] y2);
      line_type r;
      longint dy, dx, c, g;
      dy = longint'(y1) - longint'(y2);
      dx = longint'(x2) - longint'(x1);
      c = longint'(x1) * longint'(y2) - longint'(x2) * longint'(y1);
      r = '0;
      if (dy == 0 && dx == 0) begin
         r.degen = 1'b1;
         return r;
      end
      g = longint'(gcd_of(dy < 0 ? -dy : dy, dx < 0 ? -dx : dx));
      dy = dy / g;
      dx = dx / g;
      c = c / g;
      if (dx < 0 || (dx == 0 && dy < 0)) begin
         dy = -dy;
         dx = -dx;
         c = -c;
      end
      r.dy = dy[CB:0];
      r.dx = dx[CB-1:0];
      r.cst = c[2*CB:0];
      return r;
   endfunction

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // result stall pattern, with quiet stretches
   int stall_left = 0;
   int quiet_left = 0;
   always @(posedge clock) begin
      if (quiet_left > 0) begin
         quiet_left <= quiet_left - 1;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 99) < 3) quiet_left <= $urandom_range(50, 300);
         else stall_left <= gap_length();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         line_type want;
         if (expected_lines.size() == 0) begin
            $display("%0t: unexpected word dy=%0d dx=%0d c=%0d degen=%0b", $time,
                     rsp_coef_dy, rsp_coef_dx, rsp_coef_const, rsp_degenerate);
            errors++;
         end else begin
            want = expected_lines.pop_front();
            lines_checked++;
            if (rsp_degenerate) degenerate_seen++;
            if (rsp_coef_dy !== want.dy) begin
               $display("%0t: dy expected %0d actual %0d", $time, want.dy, rsp_coef_dy);
               errors++;
            end
            if (rsp_coef_dx !== want.dx) begin
               $display("%0t: dx expected %0d actual %0d", $time, want.dx, rsp_coef_dx);
               errors++;
            end
            if (rsp_coef_const !== want.cst) begin
               $display("%0t: const expected %0d actual %0d", $time, want.cst,
                        rsp_coef_const);
               errors++;
            end
            if (rsp_degenerate !== want.degen) begin
               $display("%0t: degenerate expected %0b actual %0b", $time, want.degen,
                        rsp_degenerate);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else if (!stimulus_done || expected_lines.size() != 0) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("canonical_line_from_two_points_top_tb: errors");
         $finish;
      end
   end

   task automatic send_points(logic signed [CB-1:0] x1, logic signed [CB-1:0] y1,
                              logic signed [CB-1:0] x2, logic signed [CB-1:0] y2,
                              bit allow_gap = 1'b1);
      int gap;
      gap = allow_gap ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_x <= x1;
      req_first_y <= y1;
      req_second_x <= x2;
      req_second_y <= y2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_lines.insert(expected_lines.size(), line_through(x1, y1, x2, y2));
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic signed [CB-1:0] mx, mn;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      send_points(0, 0, 0, 0);
      send_points(mx, mn, mx, mn);
      send_points(mn, mn, mx, mx);
      send_points(mx, mx, mn, mn);
      send_points(mn, mx, mx, mn);
      send_points(mx, mn, mn, mx);
      send_points(5, 3, 5, -7);
      send_points(5, -7, 5, 3);
      send_points(-4, 9, 8, 9);
      send_points(8, 9, -4, 9);
      send_points(mn, 0, mx, 0);
      send_points(0, mn, 0, mx);
      send_points(1, 2, 3, 4);
      send_points(6, 12, 18, 24);
      send_points(-1, -1, -1, -1);
      send_points(mx, mx, mx - 1, mn);
      send_points(mn, mn, mn + 1, mx);
      send_points(2, 0, 0, 2);
   endtask

   task automatic test_random(int count);
      logic signed [CB-1:0] x1, y1, x2, y2;
      int kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         x1 = CB'($urandom); y1 = CB'($urandom); x2 = CB'($urandom); y2 = CB'($urandom);
         case (kind)
            0: begin x2 = x1; y2 = y1; end
            1: x2 = x1;
            2: y2 = y1;
            3: begin
               // small multiples give large common divisors
               x2 = x1 + CB'($urandom_range(0, 7) * 64);
               y2 = y1 - CB'($urandom_range(0, 7) * 128);
            end
            4: begin
               x1 = CB'($urandom_range(0, 15)); y1 = CB'($urandom_range(0, 15));
               x2 = CB'($urandom_range(0, 15)); y2 = CB'($urandom_range(0, 15));
            end
            default: ;
         endcase
         send_points(x1, y1, x2, y2, i % 200 < 150);
      end
   endtask

   task automatic test_drain_pause();
      drain_all();
      repeat (3 * CB + 20) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random(1500);
      stimulus_done = 1'b1;
      drain_all();
      repeat (3 * CB + 20) @(posedge clock);
      $display("covered %0d point pairs, %0d coincident, with random gaps and stalls",
               lines_checked, degenerate_seen);
      if (errors == 0 && expected_lines.size() == 0) begin
         $display("canonical_line_from_two_points_top_tb: clean");
      end else begin
         $display("canonical_line_from_two_points_top_tb: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
sv/clp_pkg.sv
sv/clp_gcd_pipe.sv
sv/clp_div_pipe.sv
sv/canonical_line_from_two_points_top.sv
tb/canonical_line_from_two_points_top_tb.sv
